/* rtl/core/tilerot_pkg.sv */
// ----------------------------------------------------------------------------
// tilerot_pkg
// Shared types, constants and the byte swizzle function for the RGBA tile
// rotator.
// ----------------------------------------------------------------------------
package tilerot_pkg;

    // default tile side in pixels
    localparam int TILE_SIDE_DEFAULT = 4;

    // fixed field widths
    localparam int PIXEL_W   = 32;
    localparam int POS_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ORDER = 1'b1;

    // identity byte order after reset
    localparam logic [CFG_W-1:0] CHANNEL_ORDER_RESET = 32'h0001_0203;

    // rotation codes
    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    // control states
    typedef enum logic [0:0] {
        ST_FILL  = 1'b0,
        ST_DRAIN = 1'b1
    } state_t;

    // permute the four bytes of a pixel; top selector byte feeds output byte 0,
    // only the low two bits of each selector count
    function automatic logic [PIXEL_W-1:0] swizzle(
        input logic [PIXEL_W-1:0] px,
        input logic [CFG_W-1:0]   order
    );
        logic [PIXEL_W-1:0] res;
        logic [1:0]         sel;
        res = '0;
        for (int k = 0; k < 4; k++) begin
            sel = order[(24 - 8 * k) +: 2];
            res[8 * k +: 8] = px[{sel, 3'b000} +: 8];
        end
        return res;
    endfunction

endpackage

/* rtl/core/rgba_tile_rotate_with_channel_swizzle.sv */
// ----------------------------------------------------------------------------
// rgba_tile_rotate_with_channel_swizzle
// Collects one square RGBA32 tile, then streams it out rotated by 0, 90, 180
// or 270 degrees with each pixel's bytes permuted by the channel order.
// ----------------------------------------------------------------------------
// Source pixels are taken at one per cycle while s_ready is high, in row-major
// order into a single tile memory of TILE_SIDE*TILE_SIDE words. The
// transaction that completes the tile samples rotation and channel_order; the
// tile is then read back in destination row-major order, one memory read per
// cycle while the output is not stalled, and emitted at one pixel per cycle
// while m_ready stays high. The input is held off from the completing
// transaction until the last read of the tile has been issued, so no source
// pixel is taken while the tile's reads are being issued. The completing pixel
// of the next tile also waits until the previous tile's last pixel has left
// the output register.
module rgba_tile_rotate_with_channel_swizzle
    import tilerot_pkg::*;
#(
    parameter int TILE_SIDE = TILE_SIDE_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,

    // source pixel channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PIXEL_W-1:0]   s_src_pixel,

    // rotated pixel channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PIXEL_W-1:0]   m_dst_pixel,
    output logic [POS_W-1:0]     m_out_row,
    output logic [POS_W-1:0]     m_out_col,
    output logic                 m_tile_last
);

    localparam int AREA   = TILE_SIDE * TILE_SIDE;
    localparam int IDX_W  = $clog2(AREA);
    localparam int SIDE_W = $clog2(TILE_SIDE);

    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(AREA - 1);
    localparam logic [SIDE_W-1:0] SIDE_LAST = SIDE_W'(TILE_SIDE - 1);

    // configuration registers and per-tile snapshots
    rot_t               rotation_reg;
    logic [CFG_W-1:0]   channel_order_reg;
    rot_t               rot_snap_reg;
    logic [CFG_W-1:0]   order_snap_reg;

    // control
    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   fill_count_reg;
    logic [SIDE_W-1:0]  rd_row_reg;
    logic [SIDE_W-1:0]  rd_col_reg;

    // read stage
    logic               rd_valid_reg;
    logic [PIXEL_W-1:0] rd_data_reg;
    logic [SIDE_W-1:0]  rd_row_tag_reg;
    logic [SIDE_W-1:0]  rd_col_tag_reg;
    logic               rd_last_reg;

    // output stage
    logic               m_valid_reg;
    logic [PIXEL_W-1:0] m_pixel_reg;
    logic [SIDE_W-1:0]  m_row_reg;
    logic [SIDE_W-1:0]  m_col_reg;
    logic               m_last_reg;

    // tile memory
    logic [PIXEL_W-1:0] tile_mem [AREA];

    logic               s_accept;
    logic               fill_last;
    logic               tile_done;
    logic               rd_en;
    logic               rd_adv;
    logic               rd_at_end;
    logic [SIDE_W-1:0]  src_row;
    logic [SIDE_W-1:0]  src_col;
    logic [IDX_W-1:0]   rd_addr;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotation_reg      <= ROT_0;
            channel_order_reg <= CHANNEL_ORDER_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_ROTATION:      rotation_reg      <= rot_t'(cfg_wr_data[1:0]);
                CFG_CHANNEL_ORDER: channel_order_reg <= cfg_wr_data;
                default:           ;
            endcase
        end
    end

    // input handshake; the completing pixel waits for an empty read pipeline
    assign fill_last = (fill_count_reg == IDX_LAST);
    assign s_ready   = (state_reg == ST_FILL) && !(fill_last && (rd_valid_reg || m_valid_reg));
    assign s_accept  = s_valid && s_ready;
    assign tile_done = s_accept && fill_last;

    // read sequencing over the destination tile
    assign rd_adv    = rd_valid_reg && (!m_valid_reg || m_ready);
    assign rd_en     = (state_reg == ST_DRAIN) && (!rd_valid_reg || rd_adv);
    assign rd_at_end = (rd_row_reg == SIDE_LAST) && (rd_col_reg == SIDE_LAST);

    // source coordinate for the destination position
    always_comb begin
        case (rot_snap_reg)
            ROT_90: begin
                src_row = SIDE_LAST - rd_col_reg;
                src_col = rd_row_reg;
            end
            ROT_180: begin
                src_row = SIDE_LAST - rd_row_reg;
                src_col = SIDE_LAST - rd_col_reg;
            end
            ROT_270: begin
                src_row = rd_col_reg;
                src_col = SIDE_LAST - rd_row_reg;
            end
            default: begin
                src_row = rd_row_reg;
                src_col = rd_col_reg;
            end
        endcase
    end

    assign rd_addr = IDX_W'(src_row) * IDX_W'(TILE_SIDE) + IDX_W'(src_col);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL:  if (tile_done) state_next = ST_DRAIN;
            ST_DRAIN: if (rd_en && rd_at_end) state_next = ST_FILL;
            default:  state_next = ST_FILL;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_FILL;
            fill_count_reg <= '0;
            rd_row_reg     <= '0;
            rd_col_reg     <= '0;
            rot_snap_reg   <= ROT_0;
            order_snap_reg <= CHANNEL_ORDER_RESET;
        end else begin
            state_reg <= state_next;
            if (s_accept) begin
                fill_count_reg <= fill_last ? '0 : fill_count_reg + 1'b1;
            end
            if (tile_done) begin
                rot_snap_reg   <= rotation_reg;
                order_snap_reg <= channel_order_reg;
            end
            if (rd_en) begin
                if (rd_col_reg == SIDE_LAST) begin
                    rd_col_reg <= '0;
                    rd_row_reg <= (rd_row_reg == SIDE_LAST) ? '0 : rd_row_reg + 1'b1;
                end else begin
                    rd_col_reg <= rd_col_reg + 1'b1;
                end
            end
        end
    end

    // memory write port
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            tile_mem[fill_count_reg] <= s_src_pixel;
        end
    end

    // memory read port, data held while the read stage is stalled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= tile_mem[rd_addr];
        end
    end

    // read stage tags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else if (rd_en) begin
            rd_valid_reg <= 1'b1;
        end else if (rd_adv) begin
            rd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_row_tag_reg <= rd_row_reg;
            rd_col_tag_reg <= rd_col_reg;
            rd_last_reg    <= rd_at_end;
        end
    end

    // output register with byte swizzle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rd_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_adv) begin
            m_pixel_reg <= swizzle(rd_data_reg, order_snap_reg);
            m_row_reg   <= rd_row_tag_reg;
            m_col_reg   <= rd_col_tag_reg;
            m_last_reg  <= rd_last_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_dst_pixel = m_pixel_reg;
    assign m_out_row   = POS_W'(m_row_reg);
    assign m_out_col   = POS_W'(m_col_reg);
    assign m_tile_last = m_last_reg;

    // no source pixel is written while the tile is being read out
    a_no_fill_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> !s_accept)
        else $error("source pixel accepted during tile readout");

    // a tile only completes once the previous one has fully left
    a_done_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        tile_done |-> (!rd_valid_reg && !m_valid_reg))
        else $error("tile completed with readout still in flight");

    // a stalled read stage keeps its data and its valid
    a_rd_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_valid_reg && m_valid_reg && !m_ready) |=>
            (rd_valid_reg && $stable(rd_data_reg) && $stable(rd_last_reg)))
        else $error("read stage lost data under output stall");

    // the last pixel of a tile sits at the bottom right corner
    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (m_row_reg == SIDE_LAST && m_col_reg == SIDE_LAST))
        else $error("tile_last flagged away from the final position");

    // the readout ends in the same cycle as its last read
    a_drain_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && rd_at_end) |=> (state_reg == ST_FILL && rd_valid_reg && rd_last_reg))
        else $error("readout did not finish on its last read");

endmodule
